// ===== src/gfla_pkg.sv =====
`default_nettype none

package gfla_pkg;

	// Code that stands for the zero element in exponent form
	localparam logic [7:0] ZERO_CODE = 8'hFF;

	typedef enum logic [2:0] {
		ACT_ADD      = 3'd0,
		ACT_MUL      = 3'd1,
		ACT_DIV      = 3'd2,
		ACT_POW      = 3'd3,
		ACT_EXP2POLY = 3'd4,
		ACT_POLY2EXP = 3'd5
	} action_t;

	// Per-item decode that rides along the pipe
	typedef struct packed {
		action_t action;
		logic    zero_a;
		logic    zero_b;
		logic    count_nz;
	} flags_t;

	typedef logic [7:0] table_t [256];

	// Primitive polynomials, indexed by field width
	localparam logic [8:0] PRIM_POLY [9] = '{
		9'h000, 9'h000, 9'h007, 9'h00B, 9'h013, 9'h025, 9'h043, 9'h089, 9'h11D
	};

	// Sum the q-bit digits of x; 2^q = 1 modulo 2^q-1
	function automatic logic [9:0] fold_digits(logic [23:0] x, int q);
		logic [9:0]  acc;
		logic [23:0] mask;
		acc  = '0;
		mask = (24'd1 << q) - 24'd1;
		for (int i = 0; i < 24; i++) begin
			if (i * q < 24) begin
				acc = acc + 10'((x >> (i * q)) & mask);
			end
		end
		return acc;
	endfunction

	// x modulo 2^q-1: four digit folds settle below 2^q, then map 2^q-1 to 0
	function automatic logic [7:0] mod_order(logic [23:0] x, int q);
		logic [9:0] y;
		y = fold_digits(x, q);
		y = fold_digits(24'(y), q);
		y = fold_digits(24'(y), q);
		y = fold_digits(24'(y), q);
		if (y == 10'((1 << q) - 1)) begin
			y = '0;
		end
		return y[7:0];
	endfunction

	function automatic table_t build_antilog(int q);
		table_t     t;
		logic [8:0] x;
		logic [8:0] poly;
		int         order;
		t     = '{default: 8'h00};
		x     = 9'd1;
		poly  = PRIM_POLY[q];
		order = (1 << q) - 1;
		for (int i = 0; i < 255; i++) begin
			if (i < order) begin
				t[i] = x[7:0];
				x    = x << 1;
				if (x[q]) begin
					x = x ^ poly;
				end
			end
		end
		return t;
	endfunction

	function automatic table_t build_log(int q);
		table_t     t;
		logic [8:0] x;
		logic [8:0] poly;
		int         order;
		t     = '{default: ZERO_CODE};
		x     = 9'd1;
		poly  = PRIM_POLY[q];
		order = (1 << q) - 1;
		for (int i = 0; i < 255; i++) begin
			if (i < order) begin
				t[x[7:0]] = 8'(i);
				x         = x << 1;
				if (x[q]) begin
					x = x ^ poly;
				end
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== src/gfla_req_if.sv =====
`default_nettype none

interface gfla_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  operand_a;
	logic [7:0]  operand_b;
	logic [15:0] power_count;

	modport source (
		output valid, action, operand_a, operand_b, power_count,
		input  ready
	);
	modport sink (
		input  valid, action, operand_a, operand_b, power_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/gfla_rsp_if.sv =====
`default_nettype none

interface gfla_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;
	logic       divide_by_zero;

	modport source (
		output valid, result, divide_by_zero,
		input  ready
	);
	modport sink (
		input  valid, result, divide_by_zero,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/gfla_reduce.sv =====
`default_nettype none

// Stage 1: decode zero codes, reduce exponents modulo 2^q-1
module gfla_reduce #(
	parameter int FIELD_BITS = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        up_valid,
	output logic                       up_ready,
	input  wire  [2:0]                 action,
	input  wire  [7:0]                 operand_a,
	input  wire  [7:0]                 operand_b,
	input  wire  [15:0]                power_count,
	output logic                       dn_valid,
	input  wire                        dn_ready,
	output gfla_pkg::flags_t           flags_s1,
	output logic [FIELD_BITS-1:0]      ra_s1,
	output logic [FIELD_BITS-1:0]      rb_s1,
	output logic [FIELD_BITS-1:0]      a_s1,
	output logic [15:0]                n_s1
);

	localparam logic [FIELD_BITS-1:0] ORDER = FIELD_BITS'((1 << FIELD_BITS) - 1);

	logic [7:0]       ra_full;
	logic [7:0]       rb_full;
	gfla_pkg::flags_t flags_d;

	assign up_ready = !dn_valid || dn_ready;

	always_comb begin
		ra_full          = gfla_pkg::mod_order(24'(operand_a), FIELD_BITS);
		rb_full          = gfla_pkg::mod_order(24'(operand_b), FIELD_BITS);
		flags_d.action   = gfla_pkg::action_t'(action);
		flags_d.zero_a   = (operand_a == gfla_pkg::ZERO_CODE);
		flags_d.zero_b   = (operand_b == gfla_pkg::ZERO_CODE);
		flags_d.count_nz = (power_count != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (up_ready) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			flags_s1 <= flags_d;
			ra_s1    <= ra_full[FIELD_BITS-1:0];
			rb_s1    <= rb_full[FIELD_BITS-1:0];
			a_s1     <= operand_a[FIELD_BITS-1:0];
			n_s1     <= power_count;
		end
	end

	// Reduced exponents never reach the modulus itself
	a_reduced_range: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid |-> (ra_s1 != ORDER) && (rb_s1 != ORDER))
		else $error("reduced exponent out of range");

endmodule

`default_nettype wire

// ===== src/gfla_lookup.sv =====
`default_nettype none

// Stage 2: antilog and log lookups, exponent sum, difference and product
module gfla_lookup #(
	parameter int FIELD_BITS = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        up_valid,
	output logic                       up_ready,
	input  gfla_pkg::flags_t           flags_s1,
	input  wire  [FIELD_BITS-1:0]      ra_s1,
	input  wire  [FIELD_BITS-1:0]      rb_s1,
	input  wire  [FIELD_BITS-1:0]      a_s1,
	input  wire  [15:0]                n_s1,
	output logic                       dn_valid,
	input  wire                        dn_ready,
	output gfla_pkg::flags_t           flags_s2,
	output logic [FIELD_BITS-1:0]      ra_s2,
	output logic [FIELD_BITS-1:0]      rb_s2,
	output logic [FIELD_BITS-1:0]      pa_s2,
	output logic [FIELD_BITS-1:0]      px_s2,
	output logic [7:0]                 la_s2,
	output logic [FIELD_BITS:0]        sum_s2,
	output logic [FIELD_BITS:0]        diff_s2,
	output logic [FIELD_BITS+15:0]     prod_s2
);

	localparam gfla_pkg::table_t ANTILOG = gfla_pkg::build_antilog(FIELD_BITS);
	localparam gfla_pkg::table_t LOG     = gfla_pkg::build_log(FIELD_BITS);
	localparam logic [FIELD_BITS:0] ORDER_X = (FIELD_BITS+1)'((1 << FIELD_BITS) - 1);

	logic [7:0] pa_full;
	logic [7:0] pb_full;

	assign up_ready = !dn_valid || dn_ready;

	always_comb begin
		pa_full = ANTILOG[8'(ra_s1)];
		pb_full = ANTILOG[8'(rb_s1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (up_ready) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			flags_s2 <= flags_s1;
			ra_s2    <= ra_s1;
			rb_s2    <= rb_s1;
			pa_s2    <= pa_full[FIELD_BITS-1:0];
			px_s2    <= pa_full[FIELD_BITS-1:0] ^ pb_full[FIELD_BITS-1:0];
			la_s2    <= LOG[8'(a_s1)];
			sum_s2   <= {1'b0, ra_s1} + {1'b0, rb_s1};
			diff_s2  <= {1'b0, ra_s1} + ORDER_X - {1'b0, rb_s1};
			prod_s2  <= (FIELD_BITS+16)'(ra_s1) * (FIELD_BITS+16)'(n_s1);
		end
	end

endmodule

`default_nettype wire

// ===== src/gfla_resolve.sv =====
`default_nettype none

// Stage 3: final modulo folds, log of the XOR sum, select per action
module gfla_resolve #(
	parameter int FIELD_BITS = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        up_valid,
	output logic                       up_ready,
	input  gfla_pkg::flags_t           flags_s2,
	input  wire  [FIELD_BITS-1:0]      ra_s2,
	input  wire  [FIELD_BITS-1:0]      rb_s2,
	input  wire  [FIELD_BITS-1:0]      pa_s2,
	input  wire  [FIELD_BITS-1:0]      px_s2,
	input  wire  [7:0]                 la_s2,
	input  wire  [FIELD_BITS:0]        sum_s2,
	input  wire  [FIELD_BITS:0]        diff_s2,
	input  wire  [FIELD_BITS+15:0]     prod_s2,
	output logic                       dn_valid,
	input  wire                        dn_ready,
	output logic [7:0]                 result_s3,
	output logic                       dz_s3
);

	localparam gfla_pkg::table_t LOG = gfla_pkg::build_log(FIELD_BITS);

	logic [7:0] sum_m;
	logic [7:0] diff_m;
	logic [7:0] prod_m;
	logic [7:0] lx;
	logic [7:0] result_d;
	logic       dz_d;

	assign up_ready = !dn_valid || dn_ready;

	always_comb begin
		sum_m    = gfla_pkg::mod_order(24'(sum_s2), FIELD_BITS);
		diff_m   = gfla_pkg::mod_order(24'(diff_s2), FIELD_BITS);
		prod_m   = gfla_pkg::mod_order(24'(prod_s2), FIELD_BITS);
		lx       = LOG[8'(px_s2)];
		result_d = gfla_pkg::ZERO_CODE;
		dz_d     = 1'b0;
		unique case (flags_s2.action)
			gfla_pkg::ACT_ADD: begin
				if (flags_s2.zero_a) begin
					result_d = flags_s2.zero_b ? gfla_pkg::ZERO_CODE : 8'(rb_s2);
				end else if (flags_s2.zero_b) begin
					result_d = 8'(ra_s2);
				end else begin
					result_d = lx;
				end
			end
			gfla_pkg::ACT_MUL: begin
				if (!(flags_s2.zero_a || flags_s2.zero_b)) begin
					result_d = sum_m;
				end
			end
			gfla_pkg::ACT_DIV: begin
				if (flags_s2.zero_b) begin
					dz_d = 1'b1;
				end else if (!flags_s2.zero_a) begin
					result_d = diff_m;
				end
			end
			gfla_pkg::ACT_POW: begin
				if (flags_s2.zero_a) begin
					result_d = flags_s2.count_nz ? gfla_pkg::ZERO_CODE : 8'd0;
				end else begin
					result_d = prod_m;
				end
			end
			gfla_pkg::ACT_EXP2POLY: begin
				result_d = flags_s2.zero_a ? 8'd0 : 8'(pa_s2);
			end
			gfla_pkg::ACT_POLY2EXP: begin
				result_d = la_s2;
			end
			default: begin
				result_d = gfla_pkg::ZERO_CODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (up_ready) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			result_s3 <= result_d;
			dz_s3     <= dz_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/gf_log_domain_alu_top.sv =====
`default_nettype none

// Channel   Modport  Beat contents
// --------  -------  ---------------------------------------------------
// request   sink     action, operand_a, operand_b, power_count
// response  source   result, divide_by_zero
//
// Each beat passes the three register stages (reduce, lookup, resolve) in order;
// one beat per cycle is sustained while the response side is ready.
// arst_n clears the stage valid bits only; payload registers are not reset.
// Each stage holds while its successor is full and stalled, and takes a new beat
// as soon as it empties, so bubbles fill under a stalled response.
module gf_log_domain_alu_top #(
	parameter int FIELD_BITS = 8
) (
	input wire           clk,
	input wire           arst_n,
	gfla_req_if.sink     request,
	gfla_rsp_if.source   response
);

	// Stage 1 -> 2
	logic                    v_s1;
	logic                    ready_s2;
	gfla_pkg::flags_t        flags_s1;
	logic [FIELD_BITS-1:0]   ra_s1;
	logic [FIELD_BITS-1:0]   rb_s1;
	logic [FIELD_BITS-1:0]   a_s1;
	logic [15:0]             n_s1;

	// Stage 2 -> 3
	logic                    v_s2;
	logic                    ready_s3;
	gfla_pkg::flags_t        flags_s2;
	logic [FIELD_BITS-1:0]   ra_s2;
	logic [FIELD_BITS-1:0]   rb_s2;
	logic [FIELD_BITS-1:0]   pa_s2;
	logic [FIELD_BITS-1:0]   px_s2;
	logic [7:0]              la_s2;
	logic [FIELD_BITS:0]     sum_s2;
	logic [FIELD_BITS:0]     diff_s2;
	logic [FIELD_BITS+15:0]  prod_s2;

	// Reduce operands to exponents below 2^q-1 and decode zero codes
	gfla_reduce #(
		.FIELD_BITS (FIELD_BITS)
	) u_reduce (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (request.valid),
		.up_ready    (request.ready),
		.action      (request.action),
		.operand_a   (request.operand_a),
		.operand_b   (request.operand_b),
		.power_count (request.power_count),
		.dn_valid    (v_s1),
		.dn_ready    (ready_s2),
		.flags_s1    (flags_s1),
		.ra_s1       (ra_s1),
		.rb_s1       (rb_s1),
		.a_s1        (a_s1),
		.n_s1        (n_s1)
	);

	// Convert to polynomial form, form exponent sum, difference and power product
	gfla_lookup #(
		.FIELD_BITS (FIELD_BITS)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_ready (ready_s2),
		.flags_s1 (flags_s1),
		.ra_s1    (ra_s1),
		.rb_s1    (rb_s1),
		.a_s1     (a_s1),
		.n_s1     (n_s1),
		.dn_valid (v_s2),
		.dn_ready (ready_s3),
		.flags_s2 (flags_s2),
		.ra_s2    (ra_s2),
		.rb_s2    (rb_s2),
		.pa_s2    (pa_s2),
		.px_s2    (px_s2),
		.la_s2    (la_s2),
		.sum_s2   (sum_s2),
		.diff_s2  (diff_s2),
		.prod_s2  (prod_s2)
	);

	// Reduce modulo 2^q-1, apply the zero-element rules, drive the output register
	gfla_resolve #(
		.FIELD_BITS (FIELD_BITS)
	) u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (v_s2),
		.up_ready  (ready_s3),
		.flags_s2  (flags_s2),
		.ra_s2     (ra_s2),
		.rb_s2     (rb_s2),
		.pa_s2     (pa_s2),
		.px_s2     (px_s2),
		.la_s2     (la_s2),
		.sum_s2    (sum_s2),
		.diff_s2   (diff_s2),
		.prod_s2   (prod_s2),
		.dn_valid  (response.valid),
		.dn_ready  (response.ready),
		.result_s3 (response.result),
		.dz_s3     (response.divide_by_zero)
	);

	// A divide-by-zero beat always carries the zero element
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.divide_by_zero |-> response.result == gfla_pkg::ZERO_CODE)
		else $error("divide_by_zero with nonzero result");

	// Every result is the zero code or fits the field width
	a_result_width: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |->
			(response.result == gfla_pkg::ZERO_CODE) ||
			((9'(response.result) >> FIELD_BITS) == 9'd0))
		else $error("result outside field");

	// A beat leaving stage 2 into a free stage 3 shows up on the response
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && ready_s3 |=> response.valid)
		else $error("beat lost between stage 2 and output");

endmodule

`default_nettype wire

// ===== dv/tb_gf_log_domain_alu_top.sv =====
`default_nettype none

module tb_gf_log_domain_alu_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Multiplicative group order of GF(2^8); exponents live modulo this
	localparam int FIELD_ORDER = 255;
	// Action codes the package leaves unnamed; the block answers them with zero
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	// Cycles without any beat on either channel before the run is declared hung
	localparam int HANG_LIMIT = 5000;
	localparam int RANDOM_BEATS = 1650;

	typedef struct packed {
		logic [7:0] result;
		logic       div_zero;
	} field_result_t;

	// Tracks field operations in flight: predicts each from its request beat and
	// matches response beats against the oldest prediction.
	class field_op_board;
		logic [7:0]    antilog_lut [256];
		logic [7:0]    log_lut [256];
		field_result_t expected_results [$];
		int            errors;

		function new();
			logic [8:0] x;
			errors = 0;
			x      = 9'd1;
			foreach (log_lut[i]) begin
				log_lut[i]     = gfla_pkg::ZERO_CODE;
				antilog_lut[i] = 8'h00;
			end
			for (int i = 0; i < FIELD_ORDER; i++) begin
				antilog_lut[i]    = x[7:0];
				log_lut[x[7:0]] = 8'(i);
				x = x << 1;
				if (x[8]) begin
					x = x ^ gfla_pkg::PRIM_POLY[8];
				end
			end
		endfunction

		function field_result_t field_op_predict(logic [2:0] act, logic [7:0] a,
				logic [7:0] b, logic [15:0] n);
			field_result_t r;
			r.result   = gfla_pkg::ZERO_CODE;
			r.div_zero = 1'b0;
			case (act)
				gfla_pkg::ACT_ADD: begin
					if (a == gfla_pkg::ZERO_CODE) begin
						r.result = b;
					end else if (b == gfla_pkg::ZERO_CODE) begin
						r.result = a;
					end else begin
						r.result = log_lut[antilog_lut[a] ^ antilog_lut[b]];
					end
				end
				gfla_pkg::ACT_MUL: begin
					if (a != gfla_pkg::ZERO_CODE && b != gfla_pkg::ZERO_CODE) begin
						r.result = 8'((int'(a) + int'(b)) % FIELD_ORDER);
					end
				end
				gfla_pkg::ACT_DIV: begin
					if (b == gfla_pkg::ZERO_CODE) begin
						r.div_zero = 1'b1;
					end else if (a != gfla_pkg::ZERO_CODE) begin
						r.result = 8'((int'(a) + FIELD_ORDER - int'(b)) % FIELD_ORDER);
					end
				end
				gfla_pkg::ACT_POW: begin
					if (a == gfla_pkg::ZERO_CODE) begin
						r.result = (n != 16'd0) ? gfla_pkg::ZERO_CODE : 8'd0;
					end else begin
						r.result = 8'((int'(a) * int'(n)) % FIELD_ORDER);
					end
				end
				gfla_pkg::ACT_EXP2POLY: begin
					r.result = (a == gfla_pkg::ZERO_CODE) ? 8'd0 : antilog_lut[a];
				end
				gfla_pkg::ACT_POLY2EXP: r.result = log_lut[a];
				default:                r.result = gfla_pkg::ZERO_CODE;
			endcase
			return r;
		endfunction

		function void note_request(logic [2:0] act, logic [7:0] a, logic [7:0] b,
				logic [15:0] n);
			expected_results.push_back(field_op_predict(act, a, b, n));
		endfunction

		function void check_response(logic [7:0] res, logic dz);
			field_result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected response beat result=%0d divide_by_zero=%0b",
					$time, res, dz);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (res !== want.result) begin
				$display("%0t: result mismatch expected=%0d actual=%0d",
					$time, want.result, res);
				errors++;
			end
			if (dz !== want.div_zero) begin
				$display("%0t: divide_by_zero mismatch expected=%0b actual=%0b",
					$time, want.div_zero, dz);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	// High while both sides run without idling
	bit   steady = 1'b0;
	int   stall_cycles = 0;

	field_op_board board = new();

	gfla_req_if req_ch ();
	gfla_rsp_if rsp_ch ();

	gf_log_domain_alu_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch),
		.response (rsp_ch)
	);

	always #4 clk = ~clk;

	// Predict on every accepted request beat; sampled at the rising edge, where
	// the inputs set up at the previous falling edge are stable.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			board.note_request(req_ch.action, req_ch.operand_a, req_ch.operand_b,
				req_ch.power_count);
		end
	end

	// Check every accepted response beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			board.check_response(rsp_ch.result, rsp_ch.divide_by_zero);
		end
	end

	// Count cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (stall_cycles >= HANG_LIMIT);
		$display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Response side: drop ready in about a quarter of the cycles, except while
	// the steady stretch runs.
	initial begin : response_sink
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= 26);
		end
	end

	// Offer one request beat and hold it until accepted. Enter and leave at a
	// falling edge; valid stays high into the next beat unless an idle is drawn.
	task automatic send_beat(logic [2:0] act, logic [7:0] a, logic [7:0] b,
			logic [15:0] n);
		while (!steady && $urandom_range(99) < 26) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.operand_a   <= a;
		req_ch.operand_b   <= b;
		req_ch.power_count <= n;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Hold the request side quiet until every predicted result has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (board.pending() != 0);
	endtask

	// Exponent operand: zero code, group extremes and plain random values
	function automatic logic [7:0] pick_elem();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			return gfla_pkg::ZERO_CODE;
		end else if (r < 16) begin
			return 8'd0;
		end else if (r < 20) begin
			return 8'd254;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 16'd0;
		end else if (r < 15) begin
			return 16'hFFFF;
		end else if (r < 45) begin
			return 16'($urandom_range(600));
		end
		return 16'($urandom_range(65535));
	endfunction

	initial begin : stimulus
		logic [2:0]  act;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [15:0] n;

		req_ch.valid       = 1'b0;
		req_ch.action      = gfla_pkg::ACT_ADD;
		req_ch.operand_a   = 8'd0;
		req_ch.operand_b   = 8'd0;
		req_ch.power_count = 16'd0;

		// Hold reset, then release it at a falling edge
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: zero handling in add, equal addends cancelling to zero
		send_beat(gfla_pkg::ACT_ADD, gfla_pkg::ZERO_CODE, gfla_pkg::ZERO_CODE, 16'd0);
		send_beat(gfla_pkg::ACT_ADD, gfla_pkg::ZERO_CODE, 8'd7, 16'd0);
		send_beat(gfla_pkg::ACT_ADD, 8'd200, gfla_pkg::ZERO_CODE, 16'd0);
		send_beat(gfla_pkg::ACT_ADD, 8'd9, 8'd9, 16'd0);
		send_beat(gfla_pkg::ACT_ADD, 8'd0, 8'd25, 16'd0);
		// Multiply: wraparound at the top of the group, zero operand
		send_beat(gfla_pkg::ACT_MUL, 8'd254, 8'd254, 16'd0);
		send_beat(gfla_pkg::ACT_MUL, gfla_pkg::ZERO_CODE, 8'd3, 16'd0);
		send_beat(gfla_pkg::ACT_MUL, 8'd0, 8'd0, 16'd0);
		// Divide: zero over zero, nonzero over zero, zero over nonzero, borrow
		send_beat(gfla_pkg::ACT_DIV, gfla_pkg::ZERO_CODE, gfla_pkg::ZERO_CODE, 16'd0);
		send_beat(gfla_pkg::ACT_DIV, 8'd17, gfla_pkg::ZERO_CODE, 16'd0);
		send_beat(gfla_pkg::ACT_DIV, gfla_pkg::ZERO_CODE, 8'd40, 16'd0);
		send_beat(gfla_pkg::ACT_DIV, 8'd3, 8'd200, 16'd0);
		// Power: zero to the zeroth is one, zero to a positive count stays zero
		send_beat(gfla_pkg::ACT_POW, gfla_pkg::ZERO_CODE, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_POW, gfla_pkg::ZERO_CODE, 8'd0, 16'hFFFF);
		send_beat(gfla_pkg::ACT_POW, 8'd254, 8'd0, 16'hFFFF);
		send_beat(gfla_pkg::ACT_POW, 8'd1, 8'd0, 16'd0);
		// Conversions at both ends of the code range
		send_beat(gfla_pkg::ACT_EXP2POLY, gfla_pkg::ZERO_CODE, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_EXP2POLY, 8'd254, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_EXP2POLY, 8'd0, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_POLY2EXP, 8'd0, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_POLY2EXP, 8'hFF, 8'd0, 16'd0);
		send_beat(gfla_pkg::ACT_POLY2EXP, 8'd1, 8'd0, 16'd0);
		// Unused action codes answer with the zero element
		send_beat(ACT_SPARE_6, 8'hA5, 8'h5A, 16'h1234);
		send_beat(ACT_SPARE_7, 8'h00, gfla_pkg::ZERO_CODE, 16'hFFFF);
		drain_results();

		// Random: mostly the six operations, a trickle of unused codes
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			steady <= (i >= 900 && i < 1200);
			if (i == 500 || $urandom_range(249) == 0) begin
				drain_results();
			end
			if ($urandom_range(99) < 4) begin
				act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
			end else begin
				act = 3'($urandom_range(5));
			end
			a = (act == gfla_pkg::ACT_POLY2EXP) ? 8'($urandom_range(255)) : pick_elem();
			b = pick_elem();
			n = pick_count();
			// Force equal addends now and then so sums cancel to zero
			if (act == gfla_pkg::ACT_ADD && $urandom_range(5) == 0) begin
				b = a;
			end
			send_beat(act, a, b, n);
		end

		// Let the pipe empty, then keep watching for stray beats
		req_ch.valid <= 1'b0;
		while (board.pending() != 0) begin
			@(negedge clk);
		end
		repeat (12) @(negedge clk);

		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/gfla_pkg.sv
src/gfla_req_if.sv
src/gfla_rsp_if.sv
src/gfla_reduce.sv
src/gfla_lookup.sv
src/gfla_resolve.sv
src/gf_log_domain_alu_top.sv
dv/tb_gf_log_domain_alu_top.sv
